/* design/mdu_pkg.sv */
`timescale 1ns / 1ps
package mdu_pkg;
  localparam int DataWidth = 64;
  localparam int ProdWidth = 2 * DataWidth;
  localparam int HalfWidth = DataWidth / 2;
  localparam int DivStages = DataWidth;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [ProdWidth-1:0] prod_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;
endpackage

/* design/mdu_mul.sv */
`timescale 1ns / 1ps
module mdu_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mdu_pkg::data_t a,
  input  mdu_pkg::data_t b,
  input  mdu_pkg::data_t c,
  output logic           out_valid,
  output mdu_pkg::prod_t product,
  output mdu_pkg::data_t out_c
);
  import mdu_pkg::*;

  // stage 1: four half-width partial products
  logic [DataWidth-1:0] p00, p01, p10, p11;
  data_t c1;
  logic v1;

  always_ff @(posedge clk) begin
    p00 <= DataWidth'(a[HalfWidth-1:0]) * DataWidth'(b[HalfWidth-1:0]);
    p01 <= DataWidth'(a[HalfWidth-1:0]) * DataWidth'(b[DataWidth-1:HalfWidth]);
    p10 <= DataWidth'(a[DataWidth-1:HalfWidth]) * DataWidth'(b[HalfWidth-1:0]);
    p11 <= DataWidth'(a[DataWidth-1:HalfWidth]) * DataWidth'(b[DataWidth-1:HalfWidth]);
    c1  <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 2: sum partial products
  prod_t sum_next;
  assign sum_next = {p11, p00}
                  + (ProdWidth'(p01) << HalfWidth)
                  + (ProdWidth'(p10) << HalfWidth);

  always_ff @(posedge clk) begin
    product <= sum_next;
    out_c   <= c1;
  end
endmodule

/* design/mdu_div_stage.sv */
`timescale 1ns / 1ps
module mdu_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mdu_pkg::data_t in_rem,
  input  mdu_pkg::prod_t in_num,
  input  mdu_pkg::data_t in_quo,
  input  logic           in_ovf,
  input  mdu_pkg::data_t in_d,
  output logic           out_valid,
  output mdu_pkg::data_t out_rem,
  output mdu_pkg::prod_t out_num,
  output mdu_pkg::data_t out_quo,
  output logic           out_ovf,
  output mdu_pkg::data_t out_d
);
  import mdu_pkg::*;

  // one restoring step: shift in the top numerator bit, subtract if it fits
  logic [DataWidth:0] shifted;
  logic [DataWidth:0] diff;
  logic               fits;

  assign shifted = {in_rem, in_num[ProdWidth-1]};
  assign diff    = shifted - {1'b0, in_d};
  assign fits    = ~diff[DataWidth];

  always_ff @(posedge clk) begin
    out_rem <= fits ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
    out_num <= {in_num[ProdWidth-2:0], 1'b0};
    out_quo <= {in_quo[DataWidth-2:0], fits};
    // a quotient bit shifted out the top means the result is too wide
    out_ovf <= in_ovf | in_quo[DataWidth-1];
    out_d   <= in_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end
endmodule

/* design/mul_div_u64.sv */
`timescale 1ns / 1ps
// Unsigned (operand_a * operand_b) / divisor with a full 128-bit product.
// A new item may be started every cycle; busy is never raised. Each result
// appears with done high once its item has passed through the pipeline:
// two multiplier stages, one restoring-divide stage per quotient bit, and an
// output register. Results cannot be stalled. status 1 flags a zero divisor,
// status 2 a quotient above 64 bits; quotient is 0 in both cases.
module mul_div_u64 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [63:0]           operand_a,
  input  logic [63:0]           operand_b,
  input  logic [63:0]           divisor,
  output logic                  done,
  output logic [63:0]           quotient,
  output logic [1:0]            status
);
  import mdu_pkg::*;

  assign busy = 1'b0;

  logic  mul_valid;
  prod_t mul_prod;
  data_t mul_d;

  mdu_mul u_mul (
    .clk(clk), .rst(rst), .in_valid(start & ~busy),
    .a(operand_a), .b(operand_b), .c(divisor),
    .out_valid(mul_valid), .product(mul_prod), .out_c(mul_d)
  );

  // the high half of the product must stay below the divisor; the divide
  // chain only yields the low 64 quotient bits, so pre-check with stage 0
  logic  v   [DivStages+1];
  data_t rem [DivStages+1];
  prod_t num [DivStages+1];
  data_t quo [DivStages+1];
  logic  ovf [DivStages+1];
  data_t dd  [DivStages+1];

  // feed: start with remainder = 0 over all 128 bits is 128 steps; instead
  // take the high half as the starting remainder when it is below divisor,
  // else the quotient already exceeds 64 bits
  assign v[0]   = mul_valid;
  assign rem[0] = (mul_prod[ProdWidth-1:DataWidth] < mul_d) ?
                  mul_prod[ProdWidth-1:DataWidth] : '0;
  assign num[0] = {mul_prod[DataWidth-1:0], {DataWidth{1'b0}}};
  assign quo[0] = '0;
  assign ovf[0] = ~(mul_prod[ProdWidth-1:DataWidth] < mul_d);
  assign dd[0]  = mul_d;

  for (genvar i = 0; i < DivStages; i++) begin : g_div
    mdu_div_stage u_stage (
      .clk(clk), .rst(rst),
      .in_valid(v[i]), .in_rem(rem[i]), .in_num(num[i]), .in_quo(quo[i]),
      .in_ovf(ovf[i]), .in_d(dd[i]),
      .out_valid(v[i+1]), .out_rem(rem[i+1]), .out_num(num[i+1]),
      .out_quo(quo[i+1]), .out_ovf(ovf[i+1]), .out_d(dd[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (dd[DivStages] == '0) begin
      status   <= ST_DIV_ZERO;
      quotient <= '0;
    end else if (ovf[DivStages]) begin
      status   <= ST_OVERFLOW;
      quotient <= '0;
    end else begin
      status   <= ST_OK;
      quotient <= quo[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[DivStages];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 2'd3))
    else $error("reserved status code");
  assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (quotient == '0))
    else $error("error result with nonzero quotient");
  assert property (@(posedge clk) disable iff (rst)
    mul_valid |=> v[1])
    else $error("item lost entering divider");
endmodule

/* bench/tb_mul_div_u64.sv */
`timescale 1ns / 1ps
module tb_mul_div_u64;
  import mdu_pkg::*;

  localparam int Latency = 67;
  localparam int WatchLimit = 2000;

  typedef struct {
    data_t a;
    data_t b;
    data_t d;
  } mdu_item_t;

  typedef struct {
    data_t   q;
    status_t st;
  } mdu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  data_t operand_a = '0;
  data_t operand_b = '0;
  data_t divisor = '0;
  logic done;
  data_t quotient;
  logic [1:0] status;

  mdu_item_t pending_items[$];
  mdu_res_t  expected_quots[$];
  int idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int n_ok = 0, n_dz = 0, n_ovf = 0;
  int quiet_cycles = 0;

  mul_div_u64 DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand_a(operand_a), .operand_b(operand_b), .divisor(divisor),
    .done(done), .quotient(quotient), .status(status)
  );

  always #1 clk = ~clk;

  function automatic mdu_res_t muldiv_predict(mdu_item_t it);
    mdu_res_t r;
    logic [127:0] prod;
    logic [127:0] q;
    prod = {64'd0, it.a} * {64'd0, it.b};
    if (it.d == '0) begin
      r.q = '0;
      r.st = ST_DIV_ZERO;
    end else begin
      q = prod / {64'd0, it.d};
      if (q[127:64] != '0) begin
        r.q = '0;
        r.st = ST_OVERFLOW;
      end else begin
        r.q = q[63:0];
        r.st = ST_OK;
      end
    end
    return r;
  endfunction

  function automatic data_t rand_word();
    data_t w;
    w = {$urandom, $urandom};
    // bias toward narrow values or values with high ones so results are not all overflow
    case ($urandom_range(0, 5))
      0: w = w >> $urandom_range(0, 63);
      1: w = w >> 32;
      2: w = ~(w >> $urandom_range(0, 63));
      default: ;
    endcase
    return w;
  endfunction

  // driver: hold start until the item is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_quots.push_back(muldiv_predict('{operand_a, operand_b, divisor}));
        items_sent++;
      end
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        mdu_item_t it;
        it = pending_items.pop_front();
        start <= 1'b1;
        operand_a <= it.a;
        operand_b <= it.b;
        divisor <= it.d;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        mdu_res_t e;
        results_seen++;
        if (expected_quots.size() == 0) begin
          $error("result with no item outstanding: quotient %h status %0d",
                 quotient, status);
          errors++;
        end else begin
          e = expected_quots.pop_front();
          if (quotient !== e.q) begin
            $error("quotient: expected %h actual %h", e.q, quotient);
            errors++;
          end
          if (status !== e.st) begin
            $error("status: expected %0d actual %0d", e.st, status);
            errors++;
          end
          case (e.st)
            ST_OK: n_ok++;
            ST_DIV_ZERO: n_dz++;
            default: n_ovf++;
          endcase
        end
      end
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic add_item(data_t a, data_t b, data_t d);
    pending_items.push_back('{a, b, d});
  endtask

  task automatic run_phase(int pct, int count);
    idle_pct = pct;
    repeat (count) begin
      data_t a, b, d;
      a = rand_word();
      b = rand_word();
      d = ($urandom_range(0, 31) == 0) ? '0 : rand_word();
      add_item(a, b, d);
    end
    wait (pending_items.size() == 0);
  endtask

  initial begin
    data_t all1;
    all1 = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero divisor, overflow boundary
    add_item('0, '0, '0);
    add_item(all1, all1, '0);
    add_item('0, '0, 64'd1);
    add_item(all1, all1, all1);
    add_item(all1, 64'd1, 64'd1);
    add_item(all1, 64'd2, 64'd1);
    add_item(all1, 64'd2, 64'd2);
    add_item(all1, all1, 64'd1);
    add_item(64'h1_0000_0000, 64'h1_0000_0000, 64'd1);
    add_item(64'h1_0000_0000, 64'hFFFF_FFFF, 64'd1);
    add_item(all1, 64'd3, 64'd2);
    add_item(64'd7, 64'd9, 64'd4);
    add_item(64'h8000_0000_0000_0000, 64'd2, 64'd2);
    add_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, all1);
    add_item(all1, all1, 64'h8000_0000_0000_0000);
    add_item(all1, all1, 64'h7FFF_FFFF_FFFF_FFFF);
    add_item(64'd1, 64'd1, all1);
    wait (pending_items.size() == 0);

    run_phase(0, 500);
    run_phase(79, 300);
    run_phase(29, 400);
    run_phase(0, 300);
    run_phase(50, 300);

    @(posedge clk);
    wait (expected_quots.size() == 0);
    repeat (Latency + 5) @(posedge clk);

    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("ok %0d, zero divisor %0d, overflow %0d", n_ok, n_dz, n_ovf);
    if (errors == 0 && expected_quots.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/mdu_pkg.sv
design/mdu_mul.sv
design/mdu_div_stage.sv
design/mul_div_u64.sv
bench/tb_mul_div_u64.sv
